// ===== sv/thick_line_rasterizer_defines.svh =====
// Assertion macros for the thick line rasterizer.
// Used by the top level; no other dependencies.
`ifndef THICK_LINE_RASTERIZER_DEFINES_SVH
`define THICK_LINE_RASTERIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define TLR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define TLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tlr_pkg.sv =====
// Shared types and constants for the thick line rasterizer.
// No dependencies.
`timescale 1ns / 1ps

package tlr_pkg;

    // Default geometry
    localparam int COORD_BITS_DEF = 12;
    localparam int THICK_BITS_DEF = 6;

    // Canvas registers and pixel output widths
    localparam int REG_BITS     = 12;
    localparam int PIX_BITS     = 11;
    localparam int COLOR_BITS   = 32;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [REG_BITS-1:0] CANVAS_RESET = 12'd1024;
    localparam logic [REG_BITS-1:0] PIX_LIMIT    = 12'd2048;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_CANVAS_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CANVAS_HEIGHT = 1'd1;

    // Request action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    // Canvas bounds, already clamped to the pixel limit
    typedef struct packed {
        logic [REG_BITS-1:0] w_lim;
        logic [REG_BITS-1:0] h_lim;
    } canvas_t;

    // One brush pixel result
    typedef struct packed {
        logic                  write_pixel;
        logic [PIX_BITS-1:0]   pixel_x;
        logic [PIX_BITS-1:0]   pixel_y;
        logic [COLOR_BITS-1:0] pixel_color;
        logic                  line_last;
        logic                  busy_res;
    } pixel_t;

    // Core status toward the top level
    typedef struct packed {
        logic emit;
        logic active;
    } core_status_t;

endpackage

// ===== sv/tlr_ifs.sv =====
// Valid/ready channel interfaces for line requests and pixel results.
// Depends on tlr_pkg.
`timescale 1ns / 1ps

interface tlr_cmd_if #(
    parameter int COORD_BITS = tlr_pkg::COORD_BITS_DEF,
    parameter int THICK_BITS = tlr_pkg::THICK_BITS_DEF
);
    logic                                valid;
    logic                                ready;
    logic                                action;
    logic signed [COORD_BITS-1:0]        start_x;
    logic signed [COORD_BITS-1:0]        start_y;
    logic signed [COORD_BITS-1:0]        end_x;
    logic signed [COORD_BITS-1:0]        end_y;
    logic [THICK_BITS-1:0]               thickness;
    logic [tlr_pkg::COLOR_BITS-1:0]      color;

    modport source (
        output valid, action, start_x, start_y, end_x, end_y, thickness, color,
        input  ready
    );
    modport sink (
        input  valid, action, start_x, start_y, end_x, end_y, thickness, color,
        output ready
    );
endinterface

interface tlr_pix_if;
    logic                            valid;
    logic                            ready;
    logic                            write_pixel;
    logic [tlr_pkg::PIX_BITS-1:0]    pixel_x;
    logic [tlr_pkg::PIX_BITS-1:0]    pixel_y;
    logic [tlr_pkg::COLOR_BITS-1:0]  pixel_color;
    logic                            line_last;
    logic                            busy_res;

    modport source (
        output valid, write_pixel, pixel_x, pixel_y, pixel_color, line_last, busy_res,
        input  ready
    );
    modport sink (
        input  valid, write_pixel, pixel_x, pixel_y, pixel_color, line_last, busy_res,
        output ready
    );
endinterface

// ===== sv/tlr_canvas_regs.sv =====
// Canvas size registers with write port and clamping to the pixel limit.
// Depends on tlr_pkg.
`timescale 1ns / 1ps

module tlr_canvas_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [tlr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [tlr_pkg::REG_BITS-1:0]      cfg_data,
    output tlr_pkg::canvas_t                  canvas
);

    logic [tlr_pkg::REG_BITS-1:0] width_reg;
    logic [tlr_pkg::REG_BITS-1:0] height_reg;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= tlr_pkg::CANVAS_RESET;
            height_reg <= tlr_pkg::CANVAS_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                tlr_pkg::REG_CANVAS_WIDTH:  width_reg  <= cfg_data;
                tlr_pkg::REG_CANVAS_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp to the addressable pixel range
    always_comb
    begin
        canvas.w_lim = (width_reg > tlr_pkg::PIX_LIMIT) ? tlr_pkg::PIX_LIMIT : width_reg;
        canvas.h_lim = (height_reg > tlr_pkg::PIX_LIMIT) ? tlr_pkg::PIX_LIMIT : height_reg;
    end

endmodule

// ===== sv/tlr_line_core.sv =====
// Line walker: Bresenham state, brush offset scan and canvas clipping.
// Depends on tlr_pkg.
`timescale 1ns / 1ps

module tlr_line_core #(
    parameter int COORD_BITS = tlr_pkg::COORD_BITS_DEF,
    parameter int THICK_BITS = tlr_pkg::THICK_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               take,
    input  logic                               action,
    input  logic signed [COORD_BITS-1:0]       start_x,
    input  logic signed [COORD_BITS-1:0]       start_y,
    input  logic signed [COORD_BITS-1:0]       end_x,
    input  logic signed [COORD_BITS-1:0]       end_y,
    input  logic [THICK_BITS-1:0]              thickness,
    input  logic [tlr_pkg::COLOR_BITS-1:0]     color,
    input  tlr_pkg::canvas_t                   canvas,
    output tlr_pkg::pixel_t                    pixel,
    output tlr_pkg::core_status_t              status
);

    // Derived widths
    localparam int DW  = COORD_BITS + 1;                       // span magnitude
    localparam int EW  = COORD_BITS + 3;                       // error term
    localparam int E2W = EW + 1;                               // doubled error
    localparam int HW  = (THICK_BITS > 1) ? THICK_BITS - 1 : 1; // brush half
    localparam int OW  = HW + 2;                               // signed offset
    localparam int PW  = ((COORD_BITS > OW) ? COORD_BITS : OW) + 1;
    localparam int CW  = (PW > tlr_pkg::REG_BITS) ? PW : tlr_pkg::REG_BITS;

    logic signed [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic signed [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic signed [COORD_BITS-1:0] goal_x_reg, goal_x_next;
    logic signed [COORD_BITS-1:0] goal_y_reg, goal_y_next;
    logic [DW-1:0]                delta_x_reg, delta_x_next;
    logic [DW-1:0]                delta_y_reg, delta_y_next;
    logic                         step_x_neg_reg, step_x_neg_next;
    logic                         step_y_neg_reg, step_y_neg_next;
    logic signed [EW-1:0]         error_acc_reg, error_acc_next;
    logic [HW-1:0]                brush_half_reg, brush_half_next;
    logic signed [OW-1:0]         offset_x_reg, offset_x_next;
    logic signed [OW-1:0]         offset_y_reg, offset_y_next;
    logic [tlr_pkg::COLOR_BITS-1:0] line_color_reg, line_color_next;
    logic                         active_reg, active_next;

    // Start-request setup terms
    logic signed [DW-1:0] diff_x, diff_y;
    logic [DW-1:0]        span_x, span_y;
    logic [THICK_BITS:0]  thick_half;
    logic [HW-1:0]        half_new;

    // Step terms
    logic signed [OW-1:0]  half_s, neg_half;
    logic signed [PW-1:0]  px, py;
    logic signed [CW-1:0]  px_ext, py_ext;
    logic                  in_canvas;
    logic                  at_goal;
    logic                  last;
    logic signed [E2W-1:0] e2, dx_s, dy_s;
    logic signed [E2W:0]   err_sum;
    logic                  move_x, move_y;
    logic                  emit;

    assign emit = take && (action == tlr_pkg::ACT_STEP) && active_reg;

    // Start setup: spans and brush half
    always_comb
    begin
        diff_x     = DW'(start_x) - DW'(end_x);
        diff_y     = DW'(start_y) - DW'(end_y);
        diff_x     = $signed({start_x[COORD_BITS-1], start_x}) -
                     $signed({end_x[COORD_BITS-1], end_x});
        diff_y     = $signed({start_y[COORD_BITS-1], start_y}) -
                     $signed({end_y[COORD_BITS-1], end_y});
        span_x     = diff_x[DW-1] ? DW'(-diff_x) : DW'(diff_x);
        span_y     = diff_y[DW-1] ? DW'(-diff_y) : DW'(diff_y);
        thick_half = {1'b0, thickness} >> 1;
        half_new   = thick_half[HW-1:0];
    end

    // Pixel position and canvas clip
    always_comb
    begin
        half_s    = $signed({2'b00, brush_half_reg});
        neg_half  = -half_s;
        px        = PW'(cur_x_reg) + PW'(offset_x_reg);
        py        = PW'(cur_y_reg) + PW'(offset_y_reg);
        px_ext    = CW'(px);
        py_ext    = CW'(py);
        in_canvas = !px_ext[CW-1] && !py_ext[CW-1] &&
                    (CW'(px_ext) < CW'(canvas.w_lim)) &&
                    (CW'(py_ext) < CW'(canvas.h_lim));
        at_goal   = (cur_x_reg == goal_x_reg) && (cur_y_reg == goal_y_reg);
    end

    // Bresenham move decision
    always_comb
    begin
        e2      = $signed({error_acc_reg, 1'b0});
        dx_s    = $signed(E2W'(delta_x_reg));
        dy_s    = $signed(E2W'(delta_y_reg));
        move_x  = e2 > -dy_s;
        move_y  = e2 < dx_s;
        err_sum = (E2W + 1)'(error_acc_reg)
                  - (move_x ? (E2W + 1)'(dy_s) : '0)
                  + (move_y ? (E2W + 1)'(dx_s) : '0);
    end

    // Next state
    always_comb
    begin
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        goal_x_next     = goal_x_reg;
        goal_y_next     = goal_y_reg;
        delta_x_next    = delta_x_reg;
        delta_y_next    = delta_y_reg;
        step_x_neg_next = step_x_neg_reg;
        step_y_neg_next = step_y_neg_reg;
        error_acc_next  = error_acc_reg;
        brush_half_next = brush_half_reg;
        offset_x_next   = offset_x_reg;
        offset_y_next   = offset_y_reg;
        line_color_next = line_color_reg;
        active_next     = active_reg;
        last            = 1'b0;

        if (take && (action == tlr_pkg::ACT_START))
        begin
            cur_x_next      = start_x;
            cur_y_next      = start_y;
            goal_x_next     = end_x;
            goal_y_next     = end_y;
            delta_x_next    = span_x;
            delta_y_next    = span_y;
            step_x_neg_next = !(start_x < end_x);
            step_y_neg_next = !(start_y < end_y);
            error_acc_next  = EW'(span_x) - EW'(span_y);
            brush_half_next = half_new;
            offset_x_next   = -$signed({2'b00, half_new});
            offset_y_next   = -$signed({2'b00, half_new});
            line_color_next = color;
            active_next     = 1'b1;
        end
        else if (emit)
        begin
            if (offset_x_reg < half_s)
            begin
                offset_x_next = offset_x_reg + OW'(1);
            end
            else if (offset_y_reg < half_s)
            begin
                offset_x_next = neg_half;
                offset_y_next = offset_y_reg + OW'(1);
            end
            else
            begin
                // end of brush square: finish or advance one line point
                if (at_goal)
                begin
                    last        = 1'b1;
                    active_next = 1'b0;
                end
                else
                begin
                    error_acc_next = err_sum[EW-1:0];
                    if (move_x)
                        cur_x_next = step_x_neg_reg ? cur_x_reg - COORD_BITS'(1)
                                                    : cur_x_reg + COORD_BITS'(1);
                    if (move_y)
                        cur_y_next = step_y_neg_reg ? cur_y_reg - COORD_BITS'(1)
                                                    : cur_y_reg + COORD_BITS'(1);
                end
                offset_x_next = neg_half;
                offset_y_next = neg_half;
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            goal_x_reg     <= '0;
            goal_y_reg     <= '0;
            delta_x_reg    <= '0;
            delta_y_reg    <= '0;
            step_x_neg_reg <= 1'b0;
            step_y_neg_reg <= 1'b0;
            error_acc_reg  <= '0;
            brush_half_reg <= '0;
            offset_x_reg   <= '0;
            offset_y_reg   <= '0;
            line_color_reg <= '0;
            active_reg     <= 1'b0;
        end
        else
        begin
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            goal_x_reg     <= goal_x_next;
            goal_y_reg     <= goal_y_next;
            delta_x_reg    <= delta_x_next;
            delta_y_reg    <= delta_y_next;
            step_x_neg_reg <= step_x_neg_next;
            step_y_neg_reg <= step_y_neg_next;
            error_acc_reg  <= error_acc_next;
            brush_half_reg <= brush_half_next;
            offset_x_reg   <= offset_x_next;
            offset_y_reg   <= offset_y_next;
            line_color_reg <= line_color_next;
            active_reg     <= active_next;
        end
    end

    // Result of the current step
    always_comb
    begin
        pixel.write_pixel = in_canvas;
        pixel.pixel_x     = in_canvas ? px_ext[tlr_pkg::PIX_BITS-1:0] : '0;
        pixel.pixel_y     = in_canvas ? py_ext[tlr_pkg::PIX_BITS-1:0] : '0;
        pixel.pixel_color = line_color_reg;
        pixel.line_last   = last;
        pixel.busy_res    = !last;
        status.emit       = emit;
        status.active     = active_reg;
    end

endmodule

// ===== sv/thick_line_rasterizer.sv =====
// Thick line rasterizer top level: canvas registers, line walker, result register.
// Depends on tlr_pkg, tlr_ifs, tlr_canvas_regs, tlr_line_core and the defines header.
//
//  Channel   Dir   Handshake          Moves
//  cmd       in    valid/ready        start or step request
//  pix       out   valid/ready        one brush pixel per step while a line is active
//  cfg       in    cfg_wr_en only     canvas width/height writes, no stall
//
//  One request per clock while cmd.ready is high. A step reaches pix in the cycle
//  after acceptance, through the single result register behind the walker logic.
//  cmd.ready is low only while a result sits in the register and pix.ready is low.
//  Reset clears the line state (idle) and sets the canvas to 1024 x 1024.
`timescale 1ns / 1ps

`include "thick_line_rasterizer_defines.svh"

module thick_line_rasterizer #(
    parameter int COORD_BITS = tlr_pkg::COORD_BITS_DEF,
    parameter int THICK_BITS = tlr_pkg::THICK_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    tlr_cmd_if.sink                           cmd,
    tlr_pix_if.source                         pix,
    input  logic                              cfg_wr_en,
    input  logic [tlr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [tlr_pkg::REG_BITS-1:0]      cfg_data
);

    tlr_pkg::canvas_t      canvas;
    tlr_pkg::pixel_t       pixel;
    tlr_pkg::core_status_t core_status;
    tlr_pkg::pixel_t       pixel_reg;
    logic                  out_valid_reg, out_valid_next;
    logic                  in_ready;
    logic                  take;

    // Accept whenever the result register is free or draining
    assign in_ready  = !out_valid_reg || pix.ready;
    assign take      = cmd.valid && in_ready;
    assign cmd.ready = in_ready;

    tlr_canvas_regs u_canvas (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .canvas    (canvas)
    );

    tlr_line_core #(
        .COORD_BITS (COORD_BITS),
        .THICK_BITS (THICK_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .action    (cmd.action),
        .start_x   (cmd.start_x),
        .start_y   (cmd.start_y),
        .end_x     (cmd.end_x),
        .end_y     (cmd.end_y),
        .thickness (cmd.thickness),
        .color     (cmd.color),
        .canvas    (canvas),
        .pixel     (pixel),
        .status    (core_status)
    );

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_ready)
            out_valid_next = core_status.emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && core_status.emit)
            pixel_reg <= pixel;
    end

    assign pix.valid       = out_valid_reg;
    assign pix.write_pixel = pixel_reg.write_pixel;
    assign pix.pixel_x     = pixel_reg.pixel_x;
    assign pix.pixel_y     = pixel_reg.pixel_y;
    assign pix.pixel_color = pixel_reg.pixel_color;
    assign pix.line_last   = pixel_reg.line_last;
    assign pix.busy_res    = pixel_reg.busy_res;

    // Checks
    `TLR_ASSERT_NOW(a_clip_zero, clk, rst_n, pix.valid && !pix.write_pixel, pix.pixel_x == '0 && pix.pixel_y == '0, "clipped pixel carries nonzero coordinates")
    `TLR_ASSERT_NOW(a_last_not_busy, clk, rst_n, pix.valid && pix.line_last, !pix.busy_res, "last pixel reported busy")
    `TLR_ASSERT_NEXT(a_start_active, clk, rst_n, cmd.valid && cmd.ready && cmd.action == tlr_pkg::ACT_START, core_status.active, "start request did not activate the line")
    `TLR_ASSERT_NOW(a_busy_tracks, clk, rst_n, pix.valid, core_status.active == pix.busy_res, "held result busy flag disagrees with walker state")

endmodule

// ===== bench/line_pixel_checker.sv =====
// Checker for the thick line rasterizer: watches the request, pixel and canvas ports,
// predicts every brush pixel and compares it field by field.
// Depends on tlr_pkg and the channel interfaces in tlr_ifs.
`timescale 1ns / 1ps

module line_pixel_checker
    import tlr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    tlr_cmd_if                      cmd,
    tlr_pix_if                      pix,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [REG_BITS-1:0]     cfg_data,
    output int                      fail_count,
    output int                      pending,
    output int                      lines_started,
    output int                      pixels_checked,
    output int                      pixels_clipped
);

    typedef logic signed [COORD_BITS_DEF-1:0] coord_t;

    // Canvas registers as last written
    logic [REG_BITS-1:0] canvas_w;
    logic [REG_BITS-1:0] canvas_h;

    // Line walker state
    coord_t                     cur_x, cur_y, goal_x, goal_y;
    logic [COORD_BITS_DEF:0]    span_x, span_y;
    logic                       x_neg, y_neg;
    logic signed [14:0]         err_acc;
    logic [4:0]                 half;
    logic signed [6:0]          off_x, off_y;
    logic [COLOR_BITS-1:0]      line_rgba;
    logic                       line_active;

    pixel_t expected_pixels[$];
    pixel_t want, got;

    // Start request: load endpoints, spans, directions, brush and colour
    function automatic void load_line(input coord_t sx, input coord_t sy, input coord_t ex,
                                      input coord_t ey, input logic [THICK_BITS_DEF-1:0] thick,
                                      input logic [COLOR_BITS-1:0] rgba);
        int dx, dy;
        dx = int'(sx) - int'(ex);
        dy = int'(sy) - int'(ey);
        if (dx < 0)
            dx = -dx;
        if (dy < 0)
            dy = -dy;
        cur_x       = sx;
        cur_y       = sy;
        goal_x      = ex;
        goal_y      = ey;
        span_x      = (COORD_BITS_DEF + 1)'(dx);
        span_y      = (COORD_BITS_DEF + 1)'(dy);
        x_neg       = !(sx < ex);
        y_neg       = !(sy < ey);
        err_acc     = 15'(dx - dy);
        half        = (thick <= 1) ? 5'd0 : 5'(thick / 2);
        off_x       = 7'(-int'(half));
        off_y       = 7'(-int'(half));
        line_rgba   = rgba;
        line_active = 1'b1;
    endfunction

    // Step request: emit the current brush pixel, then advance the brush scan
    // (x inner, y outer) and, after a full square, the Bresenham point.
    function automatic bit walk_brush(output pixel_t res);
        int px, py, w_lim, h_lim, e2, half_i;
        bit on_canvas, last;
        res = '0;
        if (!line_active)
            return 1'b0;
        half_i    = int'(half);
        px        = int'(cur_x) + int'(off_x);
        py        = int'(cur_y) + int'(off_y);
        w_lim     = (canvas_w < PIX_LIMIT) ? int'(canvas_w) : int'(PIX_LIMIT);
        h_lim     = (canvas_h < PIX_LIMIT) ? int'(canvas_h) : int'(PIX_LIMIT);
        on_canvas = (px >= 0) && (px < w_lim) && (py >= 0) && (py < h_lim);
        last      = 1'b0;

        if (int'(off_x) < half_i)
            off_x = off_x + 7'sd1;
        else if (int'(off_y) < half_i)
        begin
            off_x = 7'(-half_i);
            off_y = off_y + 7'sd1;
        end
        else
        begin
            if (cur_x == goal_x && cur_y == goal_y)
            begin
                last        = 1'b1;
                line_active = 1'b0;
            end
            else
            begin
                // both moves use the error term from before this point
                e2 = 2 * int'(err_acc);
                if (e2 > -int'(span_y))
                begin
                    err_acc = 15'(int'(err_acc) - int'(span_y));
                    cur_x   = coord_t'(int'(cur_x) + (x_neg ? -1 : 1));
                end
                if (e2 < int'(span_x))
                begin
                    err_acc = 15'(int'(err_acc) + int'(span_x));
                    cur_y   = coord_t'(int'(cur_y) + (y_neg ? -1 : 1));
                end
            end
            off_x = 7'(-half_i);
            off_y = 7'(-half_i);
        end

        res.write_pixel = on_canvas;
        res.pixel_x     = on_canvas ? PIX_BITS'(px) : '0;
        res.pixel_y     = on_canvas ? PIX_BITS'(py) : '0;
        res.pixel_color = line_rgba;
        res.line_last   = last;
        res.busy_res    = line_active;
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Monitor: results first, then the accepted request (it sees the canvas
    // from before this edge), then register writes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_w       = CANVAS_RESET;
            canvas_h       = CANVAS_RESET;
            cur_x          = '0;
            cur_y          = '0;
            goal_x         = '0;
            goal_y         = '0;
            span_x         = '0;
            span_y         = '0;
            x_neg          = 1'b0;
            y_neg          = 1'b0;
            err_acc        = '0;
            half           = '0;
            off_x          = '0;
            off_y          = '0;
            line_rgba      = '0;
            line_active    = 1'b0;
            fail_count     = 0;
            lines_started  = 0;
            pixels_checked = 0;
            pixels_clipped = 0;
            expected_pixels.delete();
            pending        = 0;
        end
        else
        begin
            if (pix.valid && pix.ready)
            begin
                got = '{pix.write_pixel, pix.pixel_x, pix.pixel_y, pix.pixel_color,
                        pix.line_last, pix.busy_res};
                if (expected_pixels.size() == 0)
                begin
                    $error("pixel with no request waiting: x %0d y %0d",
                           got.pixel_x, got.pixel_y);
                    fail_count++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_field("write_pixel", want.write_pixel, got.write_pixel);
                    check_field("pixel_x", want.pixel_x, got.pixel_x);
                    check_field("pixel_y", want.pixel_y, got.pixel_y);
                    check_field("pixel_color", want.pixel_color, got.pixel_color);
                    check_field("line_last", want.line_last, got.line_last);
                    check_field("busy_res", want.busy_res, got.busy_res);
                    pixels_checked++;
                end
            end

            if (cmd.valid && cmd.ready)
            begin
                if (cmd.action == ACT_START)
                begin
                    load_line(cmd.start_x, cmd.start_y, cmd.end_x, cmd.end_y,
                              cmd.thickness, cmd.color);
                    lines_started++;
                end
                else if (walk_brush(want))
                begin
                    expected_pixels.push_back(want);
                    if (!want.write_pixel)
                        pixels_clipped++;
                end
            end

            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_CANVAS_WIDTH:  canvas_w = cfg_data;
                    REG_CANVAS_HEIGHT: canvas_h = cfg_data;
                    default: ;
                endcase
            end

            pending = expected_pixels.size();
        end
    end

endmodule

// ===== bench/testbench.sv =====
// Top of the thick line rasterizer bench: clock, reset, request and canvas stimulus,
// output back-pressure and the verdict. Depends on tlr_pkg, tlr_ifs, the block
// and line_pixel_checker.
`timescale 1ns / 1ps

module testbench;
    import tlr_pkg::*;

    localparam int     PHASE_ITEMS    = 280;
    localparam int     SETTLE_CYCLES  = 4;
    localparam int     DRAIN_CYCLES   = 8;
    localparam int     SQUEEZE_CYCLES = 300;
    // ~2000 requests (at most ~3100 with phase overshoot); even with every request
    // meeting the longest gaps on both sides this stays under a sixth of the limit
    localparam longint TIMEOUT_NS     = 20_000_000;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_wr_en;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [REG_BITS-1:0]     cfg_data;

    int fail_count, pending, lines_started, pixels_checked, pixels_clipped;

    // Stimulus copy of the canvas, used to aim lines at its borders
    int canvas_w;
    int canvas_h;
    bit steady_send;
    bit steady_sink;
    bit squeeze_req;
    bit squeeze_done;

    tlr_cmd_if cmd_ch ();
    tlr_pix_if pix_ch ();

    thick_line_rasterizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .pix       (pix_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    line_pixel_checker pixel_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd_ch),
        .pix            (pix_ch),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending        (pending),
        .lines_started  (lines_started),
        .pixels_checked (pixels_checked),
        .pixels_clipped (pixels_clipped)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Mostly no gap, some short ones, a few long ones
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else if (r < 99)
            return $urandom_range(4, 12);
        else
            return $urandom_range(25, 60);
    endfunction

    function automatic int clamp_coord(input int v);
        if (v < -2048)
            return -2048;
        if (v > 2047)
            return 2047;
        return v;
    endfunction

    // Coordinate near the low border, near the high border, or anywhere
    function automatic int near_border(input int lim);
        int l, r;
        l = (lim > 2048) ? 2048 : lim;
        r = $urandom_range(0, 99);
        if (r < 40)
            return clamp_coord(int'($urandom_range(0, 12)) - 6);
        else if (r < 80)
            return clamp_coord(l + int'($urandom_range(0, 12)) - 6);
        else
            return int'($urandom_range(0, 4095)) - 2048;
    endfunction

    task automatic send_request(input logic act, input int sx, input int sy, input int ex,
                                input int ey, input int thick, input logic [31:0] rgba);
        int gap;
        gap = steady_send ? 0 : idle_cycles();
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.action    <= act;
        cmd_ch.start_x   <= 12'(sx);
        cmd_ch.start_y   <= 12'(sy);
        cmd_ch.end_x     <= 12'(ex);
        cmd_ch.end_y     <= 12'(ey);
        cmd_ch.thickness <= 6'(thick);
        cmd_ch.color     <= rgba;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
    endtask

    // Step request; the line fields are don't-care, so they carry noise
    task automatic send_step();
        send_request(ACT_STEP, $urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom_range(0, 63), $urandom());
    endtask

    task automatic set_canvas(input int w, input int h);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_CANVAS_WIDTH;
        cfg_data  <= 12'(w);
        @(posedge clk);
        cfg_index <= REG_CANVAS_HEIGHT;
        cfg_data  <= 12'(h);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        canvas_w = w;
        canvas_h = h;
    endtask

    // Corner cases: idle step, single pixel, full-range line, clipped thick brush,
    // widest brush, restart mid-line, short diagonal run to its last pixel
    task automatic run_directed();
        send_step();
        send_request(ACT_START, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
        send_step();
        send_request(ACT_START, -2048, -2048, 2047, 2047, 1, 32'h0000_0000);
        repeat (2) send_step();
        send_request(ACT_START, 0, 0, 0, 0, 3, 32'hA5A5_5A5A);
        repeat (9) send_step();
        send_request(ACT_START, 2047, -2048, -2048, 2047, 63, 32'h5A5A_A5A5);
        send_step();
        send_request(ACT_START, 3, 0, 0, 2, 0, 32'h1234_5678);
        repeat (4) send_step();
    endtask

    // Lines with random content: mostly short ones around the canvas borders,
    // some long thin ones cut short by the next start
    task automatic random_lines(input int budget);
        int sx, sy, ex, ey, thick, half, span, pts, steps, r, sent;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                sx = near_border(canvas_w);
                sy = near_border(canvas_h);
                ex = clamp_coord(sx + int'($urandom_range(0, 12)) - 6);
                ey = clamp_coord(sy + int'($urandom_range(0, 12)) - 6);
                r  = $urandom_range(0, 99);
                if (r < 55)
                    thick = $urandom_range(0, 3);
                else if (r < 90)
                    thick = $urandom_range(4, 9);
                else
                    thick = $urandom_range(10, 63);
            end
            else
            begin
                sx = int'($urandom_range(0, 4095)) - 2048;
                sy = int'($urandom_range(0, 4095)) - 2048;
                ex = int'($urandom_range(0, 4095)) - 2048;
                ey = int'($urandom_range(0, 4095)) - 2048;
                thick = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                     : $urandom_range(0, 1);
            end

            half = (thick <= 1) ? 0 : thick / 2;
            span = (ex > sx) ? ex - sx : sx - ex;
            if (((ey > sy) ? ey - sy : sy - ey) > span)
                span = (ey > sy) ? ey - sy : sy - ey;
            pts = (span + 1) * (2 * half + 1) * (2 * half + 1);
            if (pts <= 150 && $urandom_range(0, 7) != 0)
                steps = pts;
            else
                steps = $urandom_range(0, (pts < 40) ? pts - 1 : 40);

            send_request(ACT_START, sx, sy, ex, ey, thick, $urandom());
            repeat (steps) send_step();
            sent += 1 + steps;

            // steps after the last pixel must produce nothing
            if (steps == pts && $urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2)) send_step();
        end
    endtask

    // Drain all pixels and let the block settle before touching the canvas
    task automatic next_phase(input int w, input int h, input bit calm_send,
                              input bit calm_sink, input bit squeeze);
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        set_canvas(w, h);
        steady_send = calm_send;
        steady_sink = calm_sink;
        if (squeeze)
            squeeze_req = 1'b1;
        random_lines(PHASE_ITEMS);
    endtask

    // Pixel receiver back-pressure, with one long hold-off on request
    initial
    begin : pixel_sink
        int gap;
        pix_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (squeeze_req && !squeeze_done)
            begin
                pix_ch.ready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
                squeeze_done = 1'b1;
            end
            gap = steady_sink ? 0 : idle_cycles();
            if (gap == 0)
                pix_ch.ready <= 1'b1;
            else
            begin
                pix_ch.ready <= 1'b0;
                repeat (gap - 1) @(posedge clk);
            end
        end
    end

    // Main stimulus and verdict
    initial
    begin : stimulus
        cmd_ch.valid     <= 1'b0;
        cmd_ch.action    <= ACT_START;
        cmd_ch.start_x   <= '0;
        cmd_ch.start_y   <= '0;
        cmd_ch.end_x     <= '0;
        cmd_ch.end_y     <= '0;
        cmd_ch.thickness <= '0;
        cmd_ch.color     <= '0;
        cfg_wr_en        <= 1'b0;
        cfg_index        <= REG_CANVAS_WIDTH;
        cfg_data         <= '0;
        rst_n            <= 1'b0;
        canvas_w     = int'(CANVAS_RESET);
        canvas_h     = int'(CANVAS_RESET);
        steady_send  = 1'b0;
        steady_sink  = 1'b0;
        squeeze_req  = 1'b0;
        squeeze_done = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset canvas, then clamped, tiny, empty and odd canvases
        run_directed();
        random_lines(PHASE_ITEMS);
        next_phase(2048, 2048, 1'b1, 1'b1, 1'b0);
        next_phase(1, 1, 1'b0, 1'b0, 1'b0);
        next_phase(0, 4095, 1'b0, 1'b0, 1'b0);
        next_phase(4095, $urandom_range(1, 2048), 1'b0, 1'b0, 1'b0);
        next_phase($urandom_range(1, 2048), $urandom_range(1, 2048), 1'b1, 1'b0, 1'b1);
        next_phase($urandom_range(1, 64), $urandom_range(1, 64), 1'b0, 1'b0, 1'b0);

        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d lines over seven canvas settings, incl. empty and clamped ones.",
                 lines_started);
        $display("Compared %0d brush pixels, %0d of them off the canvas.",
                 pixels_checked, pixels_clipped);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Hang guard
    initial
    begin
        #TIMEOUT_NS;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/tlr_pkg.sv
sv/tlr_ifs.sv
sv/tlr_canvas_regs.sv
sv/tlr_line_core.sv
sv/thick_line_rasterizer.sv
bench/line_pixel_checker.sv
bench/testbench.sv
